// ===== rtl/core/v3a_pkg.sv =====
// Shared constants, types and saturation helpers for the vector ALU.
`default_nettype none
package v3a_pkg;

   localparam int LANES      = 3;
   localparam int DATA_W     = 32;
   localparam int SAT_W      = 52;
   localparam int SQRT_STEPS = 32;
   localparam int ROOT_W     = SQRT_STEPS + 1;
   localparam int DIV_STEPS  = 18;
   localparam int DIV_R_W    = ROOT_W + DIV_STEPS - 1;
   localparam int ST_MERGE   = 3;
   localparam int ST_LANE    = 5;
   localparam int ST_ROOT    = ST_MERGE + SQRT_STEPS + 1;
   localparam int ST_LAST    = ST_ROOT + DIV_STEPS;

   localparam logic signed [SAT_W-1:0] SAT_HI = 52'sd2147483647;
   localparam logic signed [SAT_W-1:0] SAT_LO = -52'sd2147483648;
   localparam logic [ROOT_W-1:0]       ROOT_MAX = 33'd2147483647;

   typedef enum logic [3:0] {
      OP_ADD, OP_SUB, OP_ADDS, OP_SUBS, OP_SCALE, OP_MUL, OP_MIN, OP_MAX,
      OP_CLAMP, OP_LERP, OP_CROSS, OP_REFLECT, OP_DOT, OP_LEN, OP_LENSQ, OP_NORM
   } op_type;

   typedef logic signed [64:0] prod_type;

   typedef struct packed {
      logic [DATA_W-1:0] val;
      logic              clip;
   } sat_type;

   typedef struct packed {
      op_type                   op;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic signed [DATA_W-1:0] c;
      logic signed [DATA_W-1:0] s;
      logic signed [DATA_W-1:0] an1;
      logic signed [DATA_W-1:0] an2;
      logic signed [DATA_W-1:0] bn1;
      logic signed [DATA_W-1:0] bn2;
   } lane_in_type;

   typedef struct packed {
      logic [DATA_W-1:0] r;
      logic              sat;
   } lane_out_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] cs;
      logic                     clip;
      logic [63:0]              sq;
   } merge_out_type;

   function automatic logic signed [SAT_W-1:0] sx(input logic signed [DATA_W-1:0] x);
      return SAT_W'(x);
   endfunction

   function automatic sat_type sat_q(input logic signed [SAT_W-1:0] v);
      sat_type res;
      res.clip = 1'b0;
      res.val  = v[DATA_W-1:0];
      if (v > SAT_HI) begin
         res.clip = 1'b1;
         res.val  = SAT_HI[DATA_W-1:0];
      end else if (v < SAT_LO) begin
         res.clip = 1'b1;
         res.val  = SAT_LO[DATA_W-1:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/v3a_req_if.sv =====
// Request channel: valid/ready handshake with operation and operands.
`default_nettype none
interface v3a_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         operation;
   logic signed [31:0] a_x;
   logic signed [31:0] a_y;
   logic signed [31:0] a_z;
   logic signed [31:0] b_x;
   logic signed [31:0] b_y;
   logic signed [31:0] b_z;
   logic signed [31:0] c_x;
   logic signed [31:0] c_y;
   logic signed [31:0] c_z;
   logic signed [31:0] scalar_in;

   modport source (output valid, operation, a_x, a_y, a_z, b_x, b_y, b_z,
                   c_x, c_y, c_z, scalar_in, input ready);
   modport sink (input valid, operation, a_x, a_y, a_z, b_x, b_y, b_z,
                 c_x, c_y, c_z, scalar_in, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/v3a_rsp_if.sv =====
// Response channel: valid/ready handshake with result vector, scalar and flags.
`default_nettype none
interface v3a_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] r_x;
   logic signed [31:0] r_y;
   logic signed [31:0] r_z;
   logic signed [31:0] r_scalar;
   logic               saturated;
   logic               degenerate;

   modport source (output valid, r_x, r_y, r_z, r_scalar, saturated, degenerate,
                   input ready);
   modport sink (input valid, r_x, r_y, r_z, r_scalar, saturated, degenerate,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/core/vec3_vector_alu.sv =====
// Three-component Q16.16 vector ALU top level: lanes, merge, square root and divider.
//
// Every operation runs through one fixed pipeline: an input register, 54 data
// stages and an output register, and a new transaction is taken every cycle
// while the output is not stalled. The depth comes from the 32-stage square
// root (two radicand bits per stage) plus its rounding stage, followed by the
// 18-stage divider used by normalize; the three lanes do the per-component
// products, rounding and saturation in stages one to five, and the merge stage
// forms the rounded dot product / sum of squares. When the response is not
// taken the whole pipe holds; the input register still takes one transaction
// while it is empty, so ready drops only when that register is also full.
// Add/sub/scale/mul/lerp/cross/reflect/dot/lensq/length clip to the signed
// 32-bit range and raise saturated; normalize of a zero vector returns zero
// with degenerate set. Results leave in request order.
`default_nettype none
module vec3_vector_alu import v3a_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   v3a_req_if.sink  req_ch,
   v3a_rsp_if.source rsp_ch
);

   typedef struct packed {
      op_type                        op;
      logic [LANES-1:0]              neg;
      logic [LANES-1:0][DATA_W-1:0]  mag;
      logic [DATA_W-1:0]             rs;
      logic                          ssat;
      logic                          deg;
      logic [LANES-1:0][DATA_W-1:0]  r;
      logic [LANES-1:0]              lsat;
   } carry_type;

   logic                     adv;
   logic                     en0;
   logic [ST_LAST:0]         v_ff;
   logic                     rsp_valid_ff;

   op_type                   op0_ff;
   logic signed [DATA_W-1:0] a0_ff [LANES];
   logic signed [DATA_W-1:0] b0_ff [LANES];
   logic signed [DATA_W-1:0] c0_ff [LANES];
   logic signed [DATA_W-1:0] s0_ff;

   lane_in_type              lane_in  [LANES];
   lane_out_type             lane_out [LANES];
   prod_type                 lane_m1  [LANES];
   merge_out_type            mo;
   logic [ROOT_W-1:0]        root;
   logic [DIV_STEPS-1:0]     div_q [LANES];

   carry_type                carry_in [1:ST_LAST];
   carry_type                carry_ff [1:ST_LAST];

   logic [DATA_W-1:0]        r_in [LANES];
   logic [DATA_W-1:0]        r_ff [LANES];
   logic [DATA_W-1:0]        rs_in, rs_ff;
   logic                     sat_in, sat_ff;
   logic                     deg_in, deg_ff;

   // advance the pipe whenever the output register is free or being drained
   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign en0          = adv || !v_ff[0];
   assign req_ch.ready = en0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en0) begin
            v_ff[0] <= req_ch.valid;
         end
         if (adv) begin
            v_ff[ST_LAST:1] <= v_ff[ST_LAST-1:0];
            rsp_valid_ff    <= v_ff[ST_LAST];
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (en0) begin
         op0_ff   <= op_type'(req_ch.operation);
         a0_ff[0] <= req_ch.a_x;
         a0_ff[1] <= req_ch.a_y;
         a0_ff[2] <= req_ch.a_z;
         b0_ff[0] <= req_ch.b_x;
         b0_ff[1] <= req_ch.b_y;
         b0_ff[2] <= req_ch.b_z;
         c0_ff[0] <= req_ch.c_x;
         c0_ff[1] <= req_ch.c_y;
         c0_ff[2] <= req_ch.c_z;
         s0_ff    <= req_ch.scalar_in;
      end
   end

   // lanes, one per component; neighbors feed the cross product
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      assign lane_in[g].op  = op0_ff;
      assign lane_in[g].a   = a0_ff[g];
      assign lane_in[g].b   = b0_ff[g];
      assign lane_in[g].c   = c0_ff[g];
      assign lane_in[g].s   = s0_ff;
      assign lane_in[g].an1 = a0_ff[(g + 1) % LANES];
      assign lane_in[g].an2 = a0_ff[(g + 2) % LANES];
      assign lane_in[g].bn1 = b0_ff[(g + 1) % LANES];
      assign lane_in[g].bn2 = b0_ff[(g + 2) % LANES];

      v3a_lane u_lane (
         .clock (clock),
         .en    (adv),
         .li    (lane_in[g]),
         .cs    (mo.cs),
         .m1    (lane_m1[g]),
         .lo    (lane_out[g])
      );

      v3a_div u_div (
         .clock (clock),
         .en    (adv),
         .mag   (carry_ff[ST_ROOT].mag[g]),
         .len   (root),
         .q     (div_q[g])
      );
   end

   v3a_merge u_merge (
      .clock (clock),
      .en    (adv),
      .m1    (lane_m1),
      .mo    (mo)
   );

   v3a_sqrt u_sqrt (
      .clock (clock),
      .en    (adv),
      .sq    (mo.sq),
      .root  (root)
   );

   // sideband carried alongside the data path; pick up results as they land
   always_comb begin
      carry_in[1]      = '0;
      carry_in[1].op   = op0_ff;
      for (int i = 0; i < LANES; i++) begin
         carry_in[1].neg[i] = a0_ff[i][DATA_W-1];
         carry_in[1].mag[i] = a0_ff[i][DATA_W-1] ? DATA_W'(-a0_ff[i]) : a0_ff[i];
      end
      for (int k = 2; k <= ST_LAST; k++) begin
         carry_in[k] = carry_ff[k-1];
         if (k == ST_MERGE + 1) begin
            if (carry_ff[k-1].op inside {OP_DOT, OP_LENSQ}) begin
               carry_in[k].rs = mo.cs;
            end
            carry_in[k].ssat = mo.clip &&
                               (carry_ff[k-1].op inside {OP_DOT, OP_REFLECT, OP_LENSQ});
            carry_in[k].deg  = (carry_ff[k-1].op == OP_NORM) && (mo.sq == '0);
         end
         if (k == ST_LANE + 1) begin
            for (int i = 0; i < LANES; i++) begin
               carry_in[k].r[i]    = lane_out[i].r;
               carry_in[k].lsat[i] = lane_out[i].sat;
            end
         end
         if ((k == ST_ROOT + 1) && (carry_ff[k-1].op == OP_LEN)) begin
            carry_in[k].rs   = (root > ROOT_MAX) ? ROOT_MAX[DATA_W-1:0] : root[DATA_W-1:0];
            carry_in[k].ssat = (root > ROOT_MAX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 1; k <= ST_LAST; k++) begin
            carry_ff[k] <= carry_in[k];
         end
      end
   end

   // output assembly: normalize takes the signed quotient, else lane results
   always_comb begin
      rs_in  = carry_ff[ST_LAST].rs;
      sat_in = (|carry_ff[ST_LAST].lsat) || carry_ff[ST_LAST].ssat;
      deg_in = carry_ff[ST_LAST].deg;
      for (int i = 0; i < LANES; i++) begin
         r_in[i] = carry_ff[ST_LAST].r[i];
         if (carry_ff[ST_LAST].op == OP_NORM) begin
            if (carry_ff[ST_LAST].deg) begin
               r_in[i] = '0;
            end else if (carry_ff[ST_LAST].neg[i]) begin
               r_in[i] = -DATA_W'(div_q[i]);
            end else begin
               r_in[i] = DATA_W'(div_q[i]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < LANES; i++) begin
            r_ff[i] <= r_in[i];
         end
         rs_ff  <= rs_in;
         sat_ff <= sat_in;
         deg_ff <= deg_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.r_x        = r_ff[0];
   assign rsp_ch.r_y        = r_ff[1];
   assign rsp_ch.r_z        = r_ff[2];
   assign rsp_ch.r_scalar   = rs_ff;
   assign rsp_ch.saturated  = sat_ff;
   assign rsp_ch.degenerate = deg_ff;

   // a degenerate normalize returns an all-zero result
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && deg_ff |-> r_ff[0] == '0 && r_ff[1] == '0 && r_ff[2] == '0 &&
                                rs_ff == '0)
      else $error("degenerate result is not zero");

   // a degenerate normalize never reports a clip
   a_deg_nosat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && deg_ff |-> !sat_ff)
      else $error("degenerate and saturated together");

   // input backpressure only with a full input register and a stalled output
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> v_ff[0] && rsp_valid_ff && !rsp_ch.ready)
      else $error("ready low without a full, stalled pipe");

endmodule
`default_nettype wire

// ===== rtl/core/v3a_lane.sv =====
// One vector lane: per-component arithmetic, stages one through five.
`default_nettype none
module v3a_lane import v3a_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  lane_in_type              li,
   input  logic signed [DATA_W-1:0] cs,
   output prod_type                 m1,
   output lane_out_type             lo
);

   logic signed [32:0]       diff;
   logic signed [32:0]       xo;
   logic signed [DATA_W-1:0] yo;
   prod_type                 m1_in;
   logic signed [63:0]       m2_in;
   sat_type                  simple_in;
   logic signed [DATA_W-1:0] mx;

   op_type                   op1_ff, op2_ff, op3_ff, op4_ff;
   logic signed [DATA_W-1:0] a1_ff, a2_ff, a3_ff, a4_ff;
   logic signed [DATA_W-1:0] b1_ff, b2_ff, b3_ff;
   prod_type                 m1_ff;
   logic signed [63:0]       m2_ff;
   sat_type                  simple1_ff, simple2_ff;
   logic signed [65:0]       t2_in, t2_ff;
   logic signed [65:0]       t2_rnd;
   logic signed [49:0]       rnd3;
   sat_type                  r3_in, r3_ff, r4_ff, r5_in, r5_ff;
   logic signed [63:0]       p4_in, p4_ff;
   logic signed [64:0]       p4_rnd;
   logic signed [49:0]       d5;

   // stage 1: operand select, products and the simple ops
   always_comb begin
      diff = 33'(li.b) - 33'(li.a);
      xo   = 33'(li.a);
      yo   = li.b;
      case (li.op)
         OP_LERP:  xo = diff;
         OP_CROSS: xo = 33'(li.an1);
         default:  xo = 33'(li.a);
      endcase
      case (li.op)
         OP_SCALE, OP_LERP:            yo = li.s;
         OP_CROSS:                     yo = li.bn2;
         OP_LEN, OP_LENSQ, OP_NORM:    yo = li.a;
         default:                      yo = li.b;
      endcase
      m1_in = xo * yo;
      m2_in = li.an2 * li.bn1;
   end

   always_comb begin
      simple_in = '0;
      mx        = ($signed(li.a) > $signed(li.b)) ? li.a : li.b;
      case (li.op)
         OP_ADD:   simple_in = sat_q(sx(li.a) + sx(li.b));
         OP_SUB:   simple_in = sat_q(sx(li.a) - sx(li.b));
         OP_ADDS:  simple_in = sat_q(sx(li.a) + sx(li.s));
         OP_SUBS:  simple_in = sat_q(sx(li.a) - sx(li.s));
         OP_MIN:   simple_in.val = ($signed(li.a) < $signed(li.b)) ? li.a : li.b;
         OP_MAX:   simple_in.val = mx;
         OP_CLAMP: simple_in.val = ($signed(mx) < $signed(li.c)) ? mx : li.c;
         default:  simple_in = '0;
      endcase
   end

   // stage 2: cross difference; stage 3: round to Q16.16 and saturate
   always_comb begin
      t2_in  = (op1_ff == OP_CROSS) ? (66'(m1_ff) - 66'(m2_ff)) : 66'(m1_ff);
      t2_rnd = t2_ff + 66'sd32768;
      rnd3   = t2_rnd[65:16];
      if (op2_ff inside {OP_SCALE, OP_MUL, OP_LERP, OP_CROSS}) begin
         r3_in = sat_q(SAT_W'(rnd3) + ((op2_ff == OP_LERP) ? sx(a2_ff) : '0));
      end else begin
         r3_in = simple2_ff;
      end
   end

   // stage 4: 2*cos*n product; stage 5: subtract from a for reflect
   always_comb begin
      p4_in  = cs * b3_ff;
      p4_rnd = 65'(p4_ff) + 65'sd16384;
      d5     = p4_rnd[64:15];
      if (op4_ff == OP_REFLECT) begin
         r5_in = sat_q(sx(a4_ff) - SAT_W'(d5));
      end else begin
         r5_in = r4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff     <= li.op;
         a1_ff      <= li.a;
         b1_ff      <= li.b;
         m1_ff      <= m1_in;
         m2_ff      <= m2_in;
         simple1_ff <= simple_in;
         op2_ff     <= op1_ff;
         a2_ff      <= a1_ff;
         b2_ff      <= b1_ff;
         t2_ff      <= t2_in;
         simple2_ff <= simple1_ff;
         op3_ff     <= op2_ff;
         a3_ff      <= a2_ff;
         b3_ff      <= b2_ff;
         r3_ff      <= r3_in;
         op4_ff     <= op3_ff;
         a4_ff      <= a3_ff;
         p4_ff      <= p4_in;
         r4_ff      <= r3_ff;
         r5_ff      <= r5_in;
      end
   end

   assign m1     = m1_ff;
   assign lo.r   = r5_ff.val;
   assign lo.sat = r5_ff.clip;

endmodule
`default_nettype wire

// ===== rtl/core/v3a_merge.sv =====
// Cross-lane merge: sum of lane products, rounded dot product and sum of squares.
`default_nettype none
module v3a_merge import v3a_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  prod_type      m1 [LANES],
   output merge_out_type mo
);

   logic signed [66:0] sum2_in, sum2_ff;
   logic signed [66:0] sum_rnd;
   logic signed [50:0] rnd;
   sat_type            cs_in;
   merge_out_type      mo_ff;

   always_comb begin
      sum2_in = 67'(m1[0]) + 67'(m1[1]) + 67'(m1[2]);
      sum_rnd = sum2_ff + 67'sd32768;
      rnd     = sum_rnd[66:16];
      cs_in   = sat_q(SAT_W'(rnd));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum2_ff     <= sum2_in;
         mo_ff.cs    <= cs_in.val;
         mo_ff.clip  <= cs_in.clip;
         mo_ff.sq    <= sum2_ff[63:0];
      end
   end

   assign mo = mo_ff;

endmodule
`default_nettype wire

// ===== rtl/core/v3a_sqrt.sv =====
// Pipelined integer square root, two radicand bits per stage, rounded to nearest.
`default_nettype none
module v3a_sqrt import v3a_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [63:0]       sq,
   output logic [ROOT_W-1:0] root
);

   logic [34:0]       rem_p  [SQRT_STEPS];
   logic [31:0]       root_p [SQRT_STEPS];
   logic [63:0]       rad_p  [SQRT_STEPS];
   logic [34:0]       rem_in [SQRT_STEPS];
   logic [31:0]       root_in[SQRT_STEPS];
   logic [63:0]       rad_in [SQRT_STEPS];
   logic [34:0]       rem_ff [SQRT_STEPS];
   logic [31:0]       root_ff[SQRT_STEPS];
   logic [63:0]       rad_ff [SQRT_STEPS];
   logic [ROOT_W-1:0] rnd_in, rnd_ff;

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
      logic [36:0] sh;
      logic [36:0] trial;
      logic [36:0] dif;
      logic        ge;
      if (g == 0) begin : g_first
         assign rem_p[g]  = '0;
         assign root_p[g] = '0;
         assign rad_p[g]  = sq;
      end else begin : g_next
         assign rem_p[g]  = rem_ff[g-1];
         assign root_p[g] = root_ff[g-1];
         assign rad_p[g]  = rad_ff[g-1];
      end
      assign sh         = {rem_p[g], rad_p[g][63:62]};
      assign trial      = {3'b000, root_p[g], 2'b01};
      assign ge         = (sh >= trial);
      assign dif        = sh - trial;
      assign rem_in[g]  = ge ? dif[34:0] : sh[34:0];
      assign root_in[g] = {root_p[g][30:0], ge};
      assign rad_in[g]  = {rad_p[g][61:0], 2'b00};
   end

   // round up where the remainder exceeds the root
   assign rnd_in = {1'b0, root_ff[SQRT_STEPS-1]} +
                   ROOT_W'(rem_ff[SQRT_STEPS-1] > {3'b000, root_ff[SQRT_STEPS-1]});

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < SQRT_STEPS; i++) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            rad_ff[i]  <= rad_in[i];
         end
         rnd_ff <= rnd_in;
      end
   end

   assign root = rnd_ff;

endmodule
`default_nettype wire

// ===== rtl/core/v3a_div.sv =====
// Pipelined restoring divider for normalize: one quotient bit per stage.
`default_nettype none
module v3a_div import v3a_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [DATA_W-1:0]    mag,
   input  logic [ROOT_W-1:0]    len,
   output logic [DIV_STEPS-1:0] q
);

   logic [DIV_R_W-1:0]   r_p  [DIV_STEPS];
   logic [DIV_STEPS-1:0] q_p  [DIV_STEPS];
   logic [ROOT_W-1:0]    l_p  [DIV_STEPS];
   logic [DIV_R_W-1:0]   r_in [DIV_STEPS];
   logic [DIV_STEPS-1:0] q_in [DIV_STEPS];
   logic [DIV_R_W-1:0]   r_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] q_ff [DIV_STEPS];
   logic [ROOT_W-1:0]    l_ff [DIV_STEPS];

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
      localparam int K = DIV_STEPS - 1 - g;
      logic [DIV_R_W-1:0] ds;
      logic               ge;
      if (g == 0) begin : g_first
         // dividend is |a| << 16 plus half the divisor for rounding
         assign r_p[g] = DIV_R_W'({mag, 16'h0000}) + DIV_R_W'(len >> 1);
         assign q_p[g] = '0;
         assign l_p[g] = len;
      end else begin : g_next
         assign r_p[g] = r_ff[g-1];
         assign q_p[g] = q_ff[g-1];
         assign l_p[g] = l_ff[g-1];
      end
      assign ds = DIV_R_W'(l_p[g]) << K;
      assign ge = (r_p[g] >= ds);
      assign r_in[g] = ge ? (r_p[g] - ds) : r_p[g];
      always_comb begin
         q_in[g]    = q_p[g];
         q_in[g][K] = ge;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < DIV_STEPS; i++) begin
            r_ff[i] <= r_in[i];
            q_ff[i] <= q_in[i];
            l_ff[i] <= l_p[i];
         end
      end
   end

   assign q = q_ff[DIV_STEPS-1];

endmodule
`default_nettype wire
